// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
// Each macro checks on the rising edge of i_clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property outside of reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check a property at every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== rtl/mrsp_pkg.sv =====
// ----------------------------------------------------------------------------
// mrsp_pkg
// Widths, status byte codes, event codes and the result record of the
// MIDI running status parser.
// ----------------------------------------------------------------------------
`default_nettype none

package mrsp_pkg;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 3;
    localparam int VALUE_W = 7;

    // Status byte codes and boundaries
    localparam logic [BYTE_W-1:0] REALTIME_MIN = 8'hF8;
    localparam logic [BYTE_W-1:0] SYS_BASE     = 8'hF0;
    localparam logic [BYTE_W-1:0] PROG_BASE    = 8'hC0;
    localparam logic [BYTE_W-1:0] PITCH_BASE   = 8'hE0;
    localparam logic [BYTE_W-1:0] SONG_POS     = 8'hF2;
    localparam logic [BYTE_W-1:0] SONG_SEL     = 8'hF3;
    localparam logic [BYTE_W-1:0] TUNE_REQ     = 8'hF6;
    localparam logic [BYTE_W-1:0] NOTE_OFF_ST  = 8'h80;
    localparam logic [BYTE_W-1:0] NOTE_ON_ST   = 8'h90;
    localparam logic [BYTE_W-1:0] CTRL_ST      = 8'hB0;
    localparam logic [BYTE_W-1:0] CHAN_MASK    = 8'hF0;
    localparam logic [BYTE_W-1:0] NO_STATUS    = 8'h00;

    // Reported event codes
    typedef enum logic [KIND_W-1:0] {
        EV_NONE     = 3'd0,
        EV_REALTIME = 3'd1,
        EV_NOTE_ON  = 3'd2,
        EV_NOTE_OFF = 3'd3,
        EV_CONTROL  = 3'd4
    } t_event_kind;

    // One result item
    typedef struct packed {
        logic [BYTE_W-1:0]  through_byte;
        t_event_kind        event_kind;
        logic [BYTE_W-1:0]  first_value;
        logic [VALUE_W-1:0] second_value;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/midi_running_status_parser.sv =====
// ----------------------------------------------------------------------------
// midi_running_status_parser
// Omni MIDI receive parser with running status: echoes every byte and
// reports realtime bytes, note on, note off and control change.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  input   | in        | i_valid / o_stall  | i_rx_byte
//  output  | out       | o_valid / i_stall  | o_through_byte, o_event_kind,
//          |           |                    | o_first_value, o_second_value
//
//  Each byte is parsed in the cycle of its transfer and its result is
//  registered on the output register; one byte per cycle while o_stall is low.
//  The parse is one level of compare logic against the running status.
//  A skid register takes one more result while the output is stalled;
//  o_stall rises only when that skid register is full.
//  Synchronous active-low reset clears the running status, the flags and
//  both valid bits.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module midi_running_status_parser (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [mrsp_pkg::BYTE_W-1:0]   i_rx_byte,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [mrsp_pkg::BYTE_W-1:0]        o_through_byte,
    output logic [mrsp_pkg::KIND_W-1:0]        o_event_kind,
    output logic [mrsp_pkg::BYTE_W-1:0]        o_first_value,
    output logic [mrsp_pkg::VALUE_W-1:0]       o_second_value
);
    import mrsp_pkg::*;

    // Parser state
    logic [BYTE_W-1:0] r_running_status, n_running_status;
    logic              r_await,          n_await;
    logic [BYTE_W-1:0] r_first_data,     n_first_data;

    // Output and skid stages
    t_result r_out,  r_skid;
    logic    r_out_valid, r_skid_valid;
    t_result n_result;

    logic              in_xfer;
    logic [BYTE_W-1:0] masked_status;

    assign in_xfer       = i_valid && !r_skid_valid;
    assign masked_status = r_running_status & CHAN_MASK;

    // Parse one byte against the running status
    always_comb begin
        n_running_status      = r_running_status;
        n_await               = r_await;
        n_first_data          = r_first_data;
        n_result.through_byte = i_rx_byte;
        n_result.event_kind   = EV_NONE;
        n_result.first_value  = '0;
        n_result.second_value = '0;

        if (i_rx_byte[BYTE_W-1]) begin
            if (i_rx_byte >= REALTIME_MIN) begin
                n_result.event_kind  = EV_REALTIME;
                n_result.first_value = i_rx_byte;
            end else begin
                n_running_status = i_rx_byte;
                n_await          = 1'b0;
                if (i_rx_byte == TUNE_REQ) begin
                    n_first_data = i_rx_byte;
                end
            end
        end else if (r_await) begin
            // Second data byte completes the message
            n_await          = 1'b0;
            n_running_status = masked_status;
            case (masked_status)
                NOTE_ON_ST: begin
                    n_result.event_kind   = EV_NOTE_ON;
                    n_result.first_value  = r_first_data;
                    n_result.second_value = i_rx_byte[VALUE_W-1:0];
                end
                NOTE_OFF_ST: begin
                    n_result.event_kind   = EV_NOTE_OFF;
                    n_result.first_value  = r_first_data;
                    n_result.second_value = i_rx_byte[VALUE_W-1:0];
                end
                CTRL_ST: begin
                    n_result.event_kind   = EV_CONTROL;
                    n_result.first_value  = r_first_data;
                    n_result.second_value = i_rx_byte[VALUE_W-1:0];
                end
                default: begin
                    n_result.event_kind = EV_NONE;
                end
            endcase
        end else if (r_running_status == NO_STATUS) begin
            // Drop data without status
            n_await = 1'b0;
        end else if (r_running_status < PROG_BASE) begin
            n_await      = 1'b1;
            n_first_data = i_rx_byte;
        end else if (r_running_status < PITCH_BASE) begin
            n_first_data = i_rx_byte;
        end else if (r_running_status < SYS_BASE) begin
            n_await      = 1'b1;
            n_first_data = i_rx_byte;
        end else if (r_running_status == SONG_POS) begin
            n_running_status = NO_STATUS;
            n_await          = 1'b1;
            n_first_data     = i_rx_byte;
        end else if (r_running_status == SONG_SEL) begin
            n_running_status = NO_STATUS;
            n_first_data     = i_rx_byte;
        end else begin
            n_running_status = NO_STATUS;
        end
    end

    // Advance parser state on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running_status <= NO_STATUS;
            r_await          <= 1'b0;
            r_first_data     <= '0;
        end else if (in_xfer) begin
            r_running_status <= n_running_status;
            r_await          <= n_await;
            r_first_data     <= n_first_data;
        end
    end

    // Output register with skid stage behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= in_xfer;
            end
        end else if (in_xfer) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_stall) begin
            r_out <= r_skid_valid ? r_skid : n_result;
        end else if (in_xfer) begin
            r_skid <= n_result;
        end
    end

    // Drive ports
    assign o_stall        = r_skid_valid;
    assign o_valid        = r_out_valid;
    assign o_through_byte = r_out.through_byte;
    assign o_event_kind   = r_out.event_kind;
    assign o_first_value  = r_out.first_value;
    assign o_second_value = r_out.second_value;

    // Checks
    `ASSERT_ALWAYS(a_skid_needs_out, (!i_rst_n || !r_skid_valid || r_out_valid), "skid full while output empty")
    `ASSERT_CLK(a_quiet_second, (o_valid && (r_out.event_kind == EV_NONE || r_out.event_kind == EV_REALTIME)) |-> (o_second_value == '0), "second value set without note or control event")
    `ASSERT_CLK(a_status_clears_await, (in_xfer && i_rx_byte[BYTE_W-1] && (i_rx_byte < REALTIME_MIN)) |=> !r_await, "status byte left second data pending")

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the MIDI running status parser. A short table of
// directed bytes walks status, data, realtime and system common cases, then
// random MIDI streams run with bursty input and a stalling output. Each
// accepted byte goes through a parser model in the bench, and each output
// transfer is compared field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import mrsp_pkg::*;

    localparam int RANDOM_ITEMS = 1750;
    localparam int IDLE_LIMIT   = 2000;
    localparam int MAX_REPORTS  = 40;
    localparam int DIRECTED_N   = 29;

    // One row of the directed table; pinned rows carry an expected result
    typedef struct packed {
        logic [BYTE_W-1:0]  rx;
        logic               pinned;
        t_event_kind        kind;
        logic [BYTE_W-1:0]  first;
        logic [VALUE_W-1:0] second;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [BYTE_W-1:0]   i_rx_byte = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [BYTE_W-1:0]   o_through_byte;
    logic [KIND_W-1:0]   o_event_kind;
    logic [BYTE_W-1:0]   o_first_value;
    logic [VALUE_W-1:0]  o_second_value;

    // Parser state as the bench sees it
    logic [BYTE_W-1:0]   model_status = NO_STATUS;
    logic                model_wait_second = 1'b0;
    logic [BYTE_W-1:0]   model_first_data = '0;

    t_result             pending_results [$];
    logic [BYTE_W-1:0]   msg_bytes [$];
    logic [BYTE_W-1:0]   gen_status = NO_STATUS;
    bit                  pin_active = 1'b0;
    t_result             pin_result = '0;
    int                  burst_left = 0;
    int                  result_errors = 0;
    int unsigned         idle_cycles = 0;
    int                  stall_left = 0;
    int                  stall_mode = 0;

    t_row directed_rows [0:DIRECTED_N-1] = '{
        '{8'h00, 1'b1, EV_NONE,     8'h00, 7'h00},  // data with no status
        '{8'hF8, 1'b1, EV_REALTIME, 8'hF8, 7'h00},
        '{8'hFF, 1'b1, EV_REALTIME, 8'hFF, 7'h00},
        '{8'h90, 1'b1, EV_NONE,     8'h00, 7'h00},
        '{8'h3C, 1'b0, EV_NONE,     8'h00, 7'h00},
        '{8'h00, 1'b1, EV_NOTE_ON,  8'h3C, 7'h00},  // note on, velocity zero
        '{8'h7F, 1'b0, EV_NONE,     8'h00, 7'h00},
        '{8'hFA, 1'b1, EV_REALTIME, 8'hFA, 7'h00},  // realtime inside a message
        '{8'h7F, 1'b1, EV_NOTE_ON,  8'h7F, 7'h7F},
        '{8'h8F, 1'b0, EV_NONE,     8'h00, 7'h00},
        '{8'h40, 1'b0, EV_NONE,     8'h00, 7'h00},
        '{8'h55, 1'b0, EV_NONE,     8'h00, 7'h00},
        '{8'hB3, 1'b0, EV_NONE,     8'h00, 7'h00},
        '{8'h07, 1'b0, EV_NONE,     8'h00, 7'h00},
        '{8'h64, 1'b0, EV_NONE,     8'h00, 7'h00},
        '{8'hC5, 1'b0, EV_NONE,     8'h00, 7'h00},
        '{8'h12, 1'b0, EV_NONE,     8'h00, 7'h00},
        '{8'hE7, 1'b0, EV_NONE,     8'h00, 7'h00},
        '{8'h00, 1'b0, EV_NONE,     8'h00, 7'h00},
        '{8'h40, 1'b0, EV_NONE,     8'h00, 7'h00},
        '{8'hF2, 1'b0, EV_NONE,     8'h00, 7'h00},
        '{8'h10, 1'b0, EV_NONE,     8'h00, 7'h00},
        '{8'h20, 1'b0, EV_NONE,     8'h00, 7'h00},
        '{8'hF3, 1'b0, EV_NONE,     8'h00, 7'h00},
        '{8'h05, 1'b0, EV_NONE,     8'h00, 7'h00},
        '{8'hF6, 1'b0, EV_NONE,     8'h00, 7'h00},
        '{8'hF0, 1'b0, EV_NONE,     8'h00, 7'h00},
        '{8'h01, 1'b0, EV_NONE,     8'h00, 7'h00},
        '{8'h02, 1'b0, EV_NONE,     8'h00, 7'h00}   // ignored after system status
    };

    midi_running_status_parser u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_through_byte (o_through_byte),
        .o_event_kind   (o_event_kind),
        .o_first_value  (o_first_value),
        .o_second_value (o_second_value)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Parse one byte and advance the bench copy of the parser state
    function automatic t_result parse_midi_byte(input logic [BYTE_W-1:0] c);
        t_result r;
        r = '0;
        r.through_byte = c;
        r.event_kind = EV_NONE;
        if (c[7]) begin
            if (c >= REALTIME_MIN) begin
                r.event_kind = EV_REALTIME;
                r.first_value = c;
            end else begin
                model_status = c;
                model_wait_second = 1'b0;
                if (c == TUNE_REQ) begin
                    model_first_data = c;
                end
            end
        end else if (model_wait_second) begin
            // second data byte completes a message; channel nibble is dropped
            model_wait_second = 1'b0;
            model_status = model_status & CHAN_MASK;
            case (model_status)
                NOTE_ON_ST:  r.event_kind = EV_NOTE_ON;
                NOTE_OFF_ST: r.event_kind = EV_NOTE_OFF;
                CTRL_ST:     r.event_kind = EV_CONTROL;
                default:     r.event_kind = EV_NONE;
            endcase
            if (r.event_kind != EV_NONE) begin
                r.first_value = model_first_data;
                r.second_value = c[VALUE_W-1:0];
            end
        end else if (model_status == NO_STATUS) begin
            // drop data with no running status
        end else if (model_status < PROG_BASE) begin
            model_wait_second = 1'b1;
            model_first_data = c;
        end else if (model_status < PITCH_BASE) begin
            model_first_data = c;
        end else if (model_status < SYS_BASE) begin
            model_wait_second = 1'b1;
            model_first_data = c;
        end else if (model_status == SONG_POS) begin
            model_status = NO_STATUS;
            model_wait_second = 1'b1;
            model_first_data = c;
        end else if (model_status == SONG_SEL) begin
            model_status = NO_STATUS;
            model_first_data = c;
        end else begin
            model_status = NO_STATUS;
        end
        return r;
    endfunction

    function automatic logic [BYTE_W-1:0] rand_data();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'h7F;
            default: return 8'($urandom_range(0, 127));
        endcase
    endfunction

    task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                               input logic [BYTE_W-1:0] got);
        if (got !== want) begin
            result_errors++;
            if (result_errors <= MAX_REPORTS) begin
                $error("%s mismatch: expected %h, actual %h", name, want, got);
            end
        end
    endtask

    // Fill msg_bytes with one MIDI message or some noise
    task automatic build_message();
        int hi;
        int n_data;
        logic [BYTE_W-1:0] status;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
                // channel voice message, often under running status
                if (gen_status != NO_STATUS && $urandom_range(0, 1) == 0) begin
                    status = gen_status;
                end else begin
                    case ($urandom_range(0, 9))
                        0, 1, 2: hi = 'h9;
                        3, 4:    hi = 'h8;
                        5, 6:    hi = 'hB;
                        7:       hi = 'hA;
                        8:       hi = $urandom_range(0, 1) ? 'hC : 'hD;
                        default: hi = 'hE;
                    endcase
                    status = {4'(hi), 4'($urandom_range(0, 15))};
                    msg_bytes.push_back(status);
                end
                gen_status = status;
                n_data = (status[7:4] == 4'hC || status[7:4] == 4'hD) ? 1 : 2;
                // truncate now and then
                if ($urandom_range(0, 11) == 0) begin
                    n_data--;
                end
                for (int i = 0; i < n_data; i++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        msg_bytes.push_back(8'($urandom_range(8'hF8, 8'hFF)));
                    end
                    msg_bytes.push_back(rand_data());
                end
            end
            6: begin
                // system common
                gen_status = NO_STATUS;
                case ($urandom_range(0, 4))
                    0: begin
                        msg_bytes.push_back(SONG_POS);
                        msg_bytes.push_back(rand_data());
                        msg_bytes.push_back(rand_data());
                    end
                    1: begin
                        msg_bytes.push_back(SONG_SEL);
                        msg_bytes.push_back(rand_data());
                    end
                    2: msg_bytes.push_back(TUNE_REQ);
                    3: begin
                        case ($urandom_range(0, 2))
                            0:       msg_bytes.push_back(8'hF1);
                            1:       msg_bytes.push_back(8'hF4);
                            default: msg_bytes.push_back(8'hF5);
                        endcase
                        msg_bytes.push_back(rand_data());
                    end
                    default: begin
                        msg_bytes.push_back(SYS_BASE);
                        n_data = $urandom_range(1, 4);
                        for (int i = 0; i < n_data; i++) begin
                            msg_bytes.push_back(rand_data());
                        end
                        msg_bytes.push_back(8'hF7);
                    end
                endcase
            end
            7: msg_bytes.push_back(8'($urandom_range(8'hF8, 8'hFF)));
            default: begin
                // raw noise
                gen_status = NO_STATUS;
                n_data = $urandom_range(1, 3);
                for (int i = 0; i < n_data; i++) begin
                    msg_bytes.push_back(8'($urandom_range(0, 255)));
                end
            end
        endcase
    endtask

    // Drive one byte in a burst and hold it until the transfer
    task automatic send_byte(input logic [BYTE_W-1:0] b, input bit pin,
                             input t_result pin_res);
        int gap;
        if (burst_left == 0) begin
            case ($urandom_range(0, 7))
                0:       gap = 0;
                1:       gap = $urandom_range(6, 15);
                default: gap = $urandom_range(1, 4);
            endcase
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        i_valid <= 1'b1;
        i_rx_byte <= b;
        pin_active = pin;
        pin_result = pin_res;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        burst_left--;
    endtask

    // Hold the input until every predicted result has come out
    task automatic hold_until_drained();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_results.size() != 0) @(negedge i_clk);
        burst_left = 0;
    endtask

    // Stall the output in modes of random length
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 120);
        end
        stall_left--;
        case (stall_mode)
            0:       i_stall <= 1'b0;
            1:       i_stall <= ($urandom_range(0, 3) == 0);
            2:       i_stall <= ($urandom_range(0, 1) == 0);
            default: i_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Predict on each input transfer, check on each output transfer
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                want = parse_midi_byte(i_rx_byte);
                if (pin_active) begin
                    want = pin_result;
                end
                pending_results.push_back(want);
            end
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    result_errors++;
                    if (result_errors <= MAX_REPORTS) begin
                        $error("unexpected result: through_byte %h", o_through_byte);
                    end
                end else begin
                    want = pending_results.pop_front();
                    check_field("through_byte", want.through_byte, o_through_byte);
                    check_field("event_kind", 8'(want.event_kind), 8'(o_event_kind));
                    check_field("first_value", want.first_value, o_first_value);
                    check_field("second_value", 8'(want.second_value), 8'(o_second_value));
                end
            end
        end
    end

    // Watchdog on cycles with no transfer at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        t_row    row;
        t_result pinned;
        int      counted;
        bit      paused_mid;
        counted = 0;
        paused_mid = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        for (int i = 0; i < DIRECTED_N; i++) begin
            row = directed_rows[i];
            pinned = '0;
            pinned.through_byte = row.rx;
            pinned.event_kind = row.kind;
            pinned.first_value = row.first;
            pinned.second_value = row.second;
            send_byte(row.rx, row.pinned, pinned);
        end
        hold_until_drained();

        // Random MIDI streams, with one full drain halfway
        while (counted < RANDOM_ITEMS) begin
            build_message();
            counted += msg_bytes.size();
            while (msg_bytes.size() != 0) begin
                send_byte(msg_bytes.pop_front(), 1'b0, '0);
            end
            if (!paused_mid && counted >= RANDOM_ITEMS / 2) begin
                hold_until_drained();
                paused_mid = 1'b1;
            end
        end

        // Drain, then let a few cycles pass for stray results
        hold_until_drained();
        repeat (4) @(posedge i_clk);
        if (result_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== midi_running_status_parser.f =====
+incdir+rtl
rtl/mrsp_pkg.sv
rtl/midi_running_status_parser.sv
tb/tb.sv
